FILE: hw/rtl/sfb_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the control store for the shape fill framebuffer.
// Used by every module under hw/rtl; depends on nothing else.

package sfb_pkg;

    // Canvas geometry and the store built from it.
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    // Signed coordinate width covers anchor +/- twice the largest height.
    localparam int CRD_W = 10;
    // Clip limits reach 64; their width is the magnitude part of a coordinate.
    localparam int LIM_W = CRD_W - 1;
    // Span counter holds up to the larger of h + 1 and the row limit.
    localparam int CNT_W = 9;
    // Configuration register width and APB address and data widths.
    localparam int CFG_W   = 7;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [7:0] DOT_CHAR = 8'h2E;

    // Step counter of the control store.
    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc PC_IDLE   = PC_W'(0);
    localparam t_pc PC_SWEEP  = PC_W'(1);
    localparam t_pc PC_CLEAR  = PC_W'(2);
    localparam t_pc PC_RECT   = PC_W'(3);
    localparam t_pc PC_UP     = PC_W'(4);
    localparam t_pc PC_DOWN   = PC_W'(5);
    localparam t_pc PC_READ   = PC_W'(6);
    localparam t_pc PC_DONE   = PC_W'(7);
    localparam t_pc PC_SPAN   = PC_W'(8);
    localparam t_pc PC_PIXEL  = PC_W'(9);
    localparam t_pc PC_STEP   = PC_W'(10);
    localparam t_pc PC_DIA1   = PC_W'(11);
    localparam t_pc PC_DSPAN  = PC_W'(12);
    localparam t_pc PC_DPIXEL = PC_W'(13);
    localparam t_pc PC_DSTEP  = PC_W'(14);
    localparam t_pc PC_DIA2   = PC_W'(15);

    // Request modes.
    typedef enum logic [2:0] {
        MODE_CLEAR   = 3'd0,
        MODE_RECT    = 3'd1,
        MODE_UP      = 3'd2,
        MODE_DOWN    = 3'd3,
        MODE_DIAMOND = 3'd4,
        MODE_READ    = 3'd5
    } t_mode;

    // Datapath operation of one control word.
    typedef enum logic [2:0] {
        UOP_IDLE  = 3'd0,
        UOP_SWEEP = 3'd1,
        UOP_LOAD  = 3'd2,
        UOP_SPAN  = 3'd3,
        UOP_PIXEL = 3'd4,
        UOP_STEP  = 3'd5,
        UOP_READ  = 3'd6,
        UOP_DONE  = 3'd7
    } t_uop;

    // Shape set-up selected by a load step.
    typedef enum logic [2:0] {
        SH_CLEAR = 3'd0,
        SH_RECT  = 3'd1,
        SH_UP    = 3'd2,
        SH_DOWN  = 3'd3,
        SH_DIA1  = 3'd4,
        SH_DIA2  = 3'd5
    } t_shape;

    // Jump condition of a control word.
    typedef enum logic [2:0] {
        CND_ALWAYS    = 3'd0,
        CND_ACCEPT    = 3'd1,
        CND_SWEEP_END = 3'd2,
        CND_CNT_ZERO  = 3'd3,
        CND_COL_END   = 3'd4,
        CND_OUT_FREE  = 3'd5
    } t_cond;

    // One control word: the jump goes to target when the condition holds (to
    // the mode's entry on accept), else it repeats (hold) or goes to the next.
    typedef struct packed {
        t_uop   op;
        t_shape shape;
        t_cond  cond;
        logic   hold;
        t_pc    target;
    } t_uword;

    // Datapath status returned to the sequencer.
    typedef struct packed {
        logic sweep_end;
        logic cnt_zero;
        logic col_end;
        logic out_free;
    } t_stat;

    // Configuration registers.
    typedef struct packed {
        logic [CFG_W-1:0] rows_in_use;
        logic [CFG_W-1:0] cols_in_use;
    } t_cfg;

    // Request and result payloads.
    typedef struct packed {
        logic [2:0]        mode;
        logic signed [7:0] pos_col;
        logic signed [7:0] pos_row;
        logic [6:0]        width;
        logic [6:0]        height;
        logic [7:0]        brush_char;
    } t_req;

    typedef struct packed {
        logic [7:0] pixel_char;
        logic       pixel_valid;
    } t_rsp;

    // Control store. A fill walks spans: each span test ends the loop when
    // the span count is spent, the pixel step writes across the span, and the
    // step word moves row and edges on. The diamond runs the loop twice.
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w = '{op: UOP_IDLE, shape: SH_CLEAR, cond: CND_ACCEPT, hold: 1'b1, target: PC_IDLE};
        unique case (pc)
            PC_IDLE:   w = '{UOP_IDLE,  SH_CLEAR, CND_ACCEPT,    1'b1, PC_IDLE};
            PC_SWEEP:  w = '{UOP_SWEEP, SH_CLEAR, CND_SWEEP_END, 1'b1, PC_IDLE};
            PC_CLEAR:  w = '{UOP_LOAD,  SH_CLEAR, CND_ALWAYS,    1'b0, PC_SPAN};
            PC_RECT:   w = '{UOP_LOAD,  SH_RECT,  CND_ALWAYS,    1'b0, PC_SPAN};
            PC_UP:     w = '{UOP_LOAD,  SH_UP,    CND_ALWAYS,    1'b0, PC_SPAN};
            PC_DOWN:   w = '{UOP_LOAD,  SH_DOWN,  CND_ALWAYS,    1'b0, PC_SPAN};
            PC_READ:   w = '{UOP_READ,  SH_CLEAR, CND_ALWAYS,    1'b0, PC_DONE};
            PC_DONE:   w = '{UOP_DONE,  SH_CLEAR, CND_OUT_FREE,  1'b1, PC_IDLE};
            PC_SPAN:   w = '{UOP_SPAN,  SH_CLEAR, CND_CNT_ZERO,  1'b0, PC_DONE};
            PC_PIXEL:  w = '{UOP_PIXEL, SH_CLEAR, CND_COL_END,   1'b1, PC_STEP};
            PC_STEP:   w = '{UOP_STEP,  SH_CLEAR, CND_ALWAYS,    1'b0, PC_SPAN};
            PC_DIA1:   w = '{UOP_LOAD,  SH_DIA1,  CND_ALWAYS,    1'b0, PC_DSPAN};
            PC_DSPAN:  w = '{UOP_SPAN,  SH_CLEAR, CND_CNT_ZERO,  1'b0, PC_DIA2};
            PC_DPIXEL: w = '{UOP_PIXEL, SH_CLEAR, CND_COL_END,   1'b1, PC_DSTEP};
            PC_DSTEP:  w = '{UOP_STEP,  SH_CLEAR, CND_ALWAYS,    1'b0, PC_DSPAN};
            PC_DIA2:   w = '{UOP_LOAD,  SH_DIA2,  CND_ALWAYS,    1'b0, PC_SPAN};
            default:   w = '{UOP_IDLE,  SH_CLEAR, CND_ACCEPT,    1'b1, PC_IDLE};
        endcase
        return w;
    endfunction

    // Entry step of the program for each request mode.
    function automatic t_pc dispatch(input logic [2:0] mode);
        t_pc pc;
        pc = PC_DONE;
        unique case (mode)
            MODE_CLEAR:   pc = PC_CLEAR;
            MODE_RECT:    pc = PC_RECT;
            MODE_UP:      pc = PC_UP;
            MODE_DOWN:    pc = PC_DOWN;
            MODE_DIAMOND: pc = PC_DIA1;
            MODE_READ:    pc = PC_READ;
            default:      pc = PC_DONE;
        endcase
        return pc;
    endfunction

endpackage

FILE: hw/rtl/shape_fill_framebuffer.sv
`timescale 1ns / 1ps
// Top level of the shape fill framebuffer: sequencer, datapath and APB registers.
// Depends on sfb_pkg, sfb_cfg_regs, sfb_sequencer and sfb_datapath.

// After reset the block sweeps the 4096-cell store to dots, one cell a cycle,
// and takes no request until the sweep ends (the clip registers can be written
// meanwhile). Requests are then handled one at a time, each giving one result.
// A request is taken at the idle step; a fill then runs one set-up step, and
// for every span (row) of the shape a span step, one pixel step per pixel of
// the unclipped span, since the single store port writes one pixel a cycle,
// and a row step, then a final span test and the final step. A diamond runs
// two span loops. A cell read registers the cell at its read step. A finished
// result is loaded at the final step into an output register and waits there,
// so the next request can be taken while it is still stalled.

module shape_fill_framebuffer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    output logic                         o_req_stall,
    input  sfb_pkg::t_req                i_req,
    output logic                         o_rsp_valid,
    input  logic                         i_rsp_stall,
    output sfb_pkg::t_rsp                o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sfb_pkg::PADDR_W-1:0]  paddr,
    input  logic [sfb_pkg::PDATA_W-1:0]  pwdata,
    output logic [sfb_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    sfb_pkg::t_cfg   cfg;
    sfb_pkg::t_uword ctl;
    sfb_pkg::t_stat  stat;
    logic            accept;

    // Clip limit registers.
    sfb_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Control store and step counter.
    sfb_sequencer u_sequencer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_mode      (i_req.mode),
        .i_stat      (stat),
        .o_req_stall (o_req_stall),
        .o_accept    (accept),
        .o_ctl       (ctl)
    );

    // Span walker, store and result register.
    sfb_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_accept    (accept),
        .i_req       (i_req),
        .i_cfg       (cfg),
        .i_rsp_stall (i_rsp_stall),
        .o_stat      (stat),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

endmodule

FILE: hw/rtl/sfb_cfg_regs.sv
`timescale 1ns / 1ps
// APB register file holding the row and column clip limits.
// Depends on sfb_pkg for widths and the configuration struct.

module sfb_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfb_pkg::PADDR_W-1:0]    paddr,
    input  logic [sfb_pkg::PDATA_W-1:0]    pwdata,
    output logic [sfb_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,
    output sfb_pkg::t_cfg                  o_cfg
);

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    logic [sfb_pkg::CFG_W-1:0] r_rows;
    logic [sfb_pkg::CFG_W-1:0] r_cols;
    logic                      wr_en;
    logic                      reg_sel;

    // Registers sit one to a 32-bit word; the low address bits are ignored.
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes complete in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= sfb_pkg::CFG_W'(64);
            r_cols <= sfb_pkg::CFG_W'(64);
        end else if (wr_en) begin
            if (reg_sel == REG_ROWS) begin
                r_rows <= pwdata[sfb_pkg::CFG_W-1:0];
            end
            if (reg_sel == REG_COLS) begin
                r_cols <= pwdata[sfb_pkg::CFG_W-1:0];
            end
        end
    end

    // Read-back of the selected register.
    always_comb begin
        prdata = '0;
        if (reg_sel == REG_COLS) begin
            prdata = sfb_pkg::PDATA_W'(r_cols);
        end else begin
            prdata = sfb_pkg::PDATA_W'(r_rows);
        end
    end

    assign o_cfg.rows_in_use = r_rows;
    assign o_cfg.cols_in_use = r_cols;

endmodule

FILE: hw/rtl/sfb_sequencer.sv
`timescale 1ns / 1ps
// Step counter and control store lookup with conditional jumps.
// Depends on sfb_pkg for the control word, the program and the dispatch table.

module sfb_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic [2:0]       i_mode,
    input  sfb_pkg::t_stat   i_stat,
    output logic             o_req_stall,
    output logic             o_accept,
    output sfb_pkg::t_uword  o_ctl
);

    sfb_pkg::t_pc    r_pc;
    sfb_pkg::t_pc    n_pc;
    sfb_pkg::t_uword ctl;
    logic            cond_hit;

    // Current control word.
    assign ctl   = sfb_pkg::ucode(r_pc);
    assign o_ctl = ctl;

    // Requests are taken only at the idle step.
    assign o_req_stall = (r_pc != sfb_pkg::PC_IDLE);
    assign o_accept    = i_req_valid && !o_req_stall;

    // Evaluate the jump condition of the current word.
    always_comb begin
        cond_hit = 1'b1;
        unique case (ctl.cond)
            sfb_pkg::CND_ALWAYS:    cond_hit = 1'b1;
            sfb_pkg::CND_ACCEPT:    cond_hit = o_accept;
            sfb_pkg::CND_SWEEP_END: cond_hit = i_stat.sweep_end;
            sfb_pkg::CND_CNT_ZERO:  cond_hit = i_stat.cnt_zero;
            sfb_pkg::CND_COL_END:   cond_hit = i_stat.col_end;
            sfb_pkg::CND_OUT_FREE:  cond_hit = i_stat.out_free;
            default:                cond_hit = 1'b1;
        endcase
    end

    // Next step: jump, repeat or fall through.
    always_comb begin
        priority if (cond_hit && ctl.cond == sfb_pkg::CND_ACCEPT) begin
            n_pc = sfb_pkg::dispatch(i_mode);
        end else if (cond_hit) begin
            n_pc = ctl.target;
        end else if (ctl.hold) begin
            n_pc = r_pc;
        end else begin
            n_pc = r_pc + sfb_pkg::PC_W'(1);
        end
    end

    // Reset starts the clearing pass over the whole store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= sfb_pkg::PC_SWEEP;
        end else begin
            r_pc <= n_pc;
        end
    end

    // The clearing pass hands over to the idle step and nowhere else.
    a_sweep_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc == sfb_pkg::PC_SWEEP && i_stat.sweep_end |=> r_pc == sfb_pkg::PC_IDLE)
        else $error("clearing pass did not return to idle");

    // An accepted request always starts a program away from idle.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_accept |=> r_pc != sfb_pkg::PC_IDLE)
        else $error("accepted request did not start a program");

    // A final step with room for its result hands back to the idle step.
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc == sfb_pkg::PC_DONE && i_stat.out_free |=> r_pc == sfb_pkg::PC_IDLE)
        else $error("final step did not return to idle");

endmodule

FILE: hw/rtl/sfb_datapath.sv
`timescale 1ns / 1ps
// Fill datapath: span registers, clipping, the character store and the result register.
// Depends on sfb_pkg; driven by control words from sfb_sequencer.

module sfb_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sfb_pkg::t_uword  i_ctl,
    input  logic             i_accept,
    input  sfb_pkg::t_req    i_req,
    input  sfb_pkg::t_cfg    i_cfg,
    input  logic             i_rsp_stall,
    output sfb_pkg::t_stat   o_stat,
    output logic             o_rsp_valid,
    output sfb_pkg::t_rsp    o_rsp
);

    localparam int CRD_W  = sfb_pkg::CRD_W;
    localparam int LIM_W  = sfb_pkg::LIM_W;
    localparam int CNT_W  = sfb_pkg::CNT_W;
    localparam int ADDR_W = sfb_pkg::ADDR_W;
    localparam int ROW_W  = sfb_pkg::ROW_W;
    localparam int COL_W  = sfb_pkg::COL_W;

    // Latched request.
    logic signed [7:0] r_x;
    logic signed [7:0] r_y;
    logic [6:0]        r_w;
    logic [6:0]        r_h;
    logic [7:0]        r_ch;

    // Span walker.
    logic signed [CRD_W-1:0] r_row;
    logic signed [CRD_W-1:0] r_lo;
    logic signed [CRD_W-1:0] r_hi;
    logic signed [CRD_W-1:0] r_col;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_row_dn;
    logic                    r_widen;
    logic [7:0]              r_fill;

    // Store, clearing pass and read path.
    logic [7:0]        r_frame_store [sfb_pkg::DEPTH];
    logic [ADDR_W-1:0] r_sweep;
    logic [7:0]        r_rd_data;
    logic              r_rd_ok;

    // Result register.
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_ok;

    logic [LIM_W-1:0]        lim_rows;
    logic [LIM_W-1:0]        lim_cols;
    logic signed [CRD_W-1:0] x_ext;
    logic signed [CRD_W-1:0] y_ext;
    logic signed [CRD_W-1:0] sel_row;
    logic signed [CRD_W-1:0] sel_col;
    logic                    in_canvas;
    logic [ADDR_W-1:0]       pix_addr;
    logic [ADDR_W-1:0]       mem_addr;
    logic                    mem_we;
    logic                    mem_re;
    logic [7:0]              mem_wdata;
    logic                    out_free;

    // Set-up values of the span walker for the shape of a load step.
    logic signed [CRD_W-1:0] ld_row;
    logic signed [CRD_W-1:0] ld_lo;
    logic signed [CRD_W-1:0] ld_hi;
    logic                    ld_row_dn;
    logic                    ld_widen;
    logic [7:0]              ld_fill;
    logic [CNT_W-1:0]        ld_cnt;

    // Clip limits are the smaller of the register and the store size.
    always_comb begin
        lim_rows = LIM_W'(i_cfg.rows_in_use);
        if (lim_rows > LIM_W'(sfb_pkg::MAX_ROWS)) begin
            lim_rows = LIM_W'(sfb_pkg::MAX_ROWS);
        end
        lim_cols = LIM_W'(i_cfg.cols_in_use);
        if (lim_cols > LIM_W'(sfb_pkg::MAX_COLS)) begin
            lim_cols = LIM_W'(sfb_pkg::MAX_COLS);
        end
    end

    assign x_ext = CRD_W'(r_x);
    assign y_ext = CRD_W'(r_y);

    // One coordinate pair per cycle: the read cell or the current pixel.
    always_comb begin
        if (i_ctl.op == sfb_pkg::UOP_READ) begin
            sel_row = y_ext;
            sel_col = x_ext;
        end else begin
            sel_row = r_row;
            sel_col = r_col;
        end
    end

    // Clipping and address of the selected cell.
    assign in_canvas = !sel_row[CRD_W-1] && (sel_row[LIM_W-1:0] < lim_rows)
                    && !sel_col[CRD_W-1] && (sel_col[LIM_W-1:0] < lim_cols);
    assign pix_addr  = ADDR_W'(ADDR_W'(sel_row[ROW_W-1:0]) * ADDR_W'(sfb_pkg::MAX_COLS))
                     + ADDR_W'(sel_col[COL_W-1:0]);

    // Single store port shared by the clearing pass, fills and reads.
    assign mem_addr  = (i_ctl.op == sfb_pkg::UOP_SWEEP) ? r_sweep : pix_addr;
    assign mem_wdata = (i_ctl.op == sfb_pkg::UOP_SWEEP) ? sfb_pkg::DOT_CHAR : r_fill;
    assign mem_we    = (i_ctl.op == sfb_pkg::UOP_SWEEP)
                    || (i_ctl.op == sfb_pkg::UOP_PIXEL && in_canvas);
    assign mem_re    = (i_ctl.op == sfb_pkg::UOP_READ);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_frame_store[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_frame_store[mem_addr];
        end
    end

    // Clearing pass address after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_ctl.op == sfb_pkg::UOP_SWEEP) begin
            r_sweep <= r_sweep + ADDR_W'(1);
        end
    end

    // Capture the request when it is taken.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_x  <= i_req.pos_col;
            r_y  <= i_req.pos_row;
            r_w  <= i_req.width;
            r_h  <= i_req.height;
            r_ch <= i_req.brush_char;
        end
    end

    // Read validity: cleared per request, set by the read step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ok <= 1'b0;
        end else if (i_accept) begin
            r_rd_ok <= 1'b0;
        end else if (i_ctl.op == sfb_pkg::UOP_READ) begin
            r_rd_ok <= in_canvas;
        end
    end

    // Shape set-up: first row, span edges, direction, widening, fill and span count.
    always_comb begin
        ld_row    = y_ext;
        ld_lo     = x_ext;
        ld_hi     = x_ext;
        ld_row_dn = 1'b0;
        ld_widen  = 1'b1;
        ld_fill   = r_ch;
        ld_cnt    = CNT_W'(r_h);
        unique case (i_ctl.shape)
            sfb_pkg::SH_CLEAR: begin
                ld_row   = '0;
                ld_lo    = '0;
                ld_hi    = CRD_W'(lim_cols) - CRD_W'(1);
                ld_widen = 1'b0;
                ld_fill  = sfb_pkg::DOT_CHAR;
                ld_cnt   = (lim_cols == '0) ? '0 : CNT_W'(lim_rows);
            end
            sfb_pkg::SH_RECT: begin
                ld_hi    = x_ext + CRD_W'(r_w) - CRD_W'(1);
                ld_widen = 1'b0;
                ld_cnt   = (r_w == '0) ? '0 : CNT_W'(r_h);
            end
            sfb_pkg::SH_UP: begin
                ld_row_dn = 1'b0;
            end
            sfb_pkg::SH_DOWN: begin
                ld_row_dn = 1'b1;
            end
            sfb_pkg::SH_DIA1: begin
                ld_cnt = CNT_W'(r_h) + CNT_W'(1);
            end
            sfb_pkg::SH_DIA2: begin
                ld_row    = y_ext + CRD_W'({r_h, 1'b0});
                ld_row_dn = 1'b1;
            end
            default: begin
                ld_cnt = '0;
            end
        endcase
    end

    // Span walker: set-up per shape, then span start, pixel advance and span step.
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            sfb_pkg::UOP_LOAD: begin
                r_row    <= ld_row;
                r_lo     <= ld_lo;
                r_hi     <= ld_hi;
                r_row_dn <= ld_row_dn;
                r_widen  <= ld_widen;
                r_fill   <= ld_fill;
                r_cnt    <= ld_cnt;
            end
            sfb_pkg::UOP_SPAN: begin
                r_col <= r_lo;
            end
            sfb_pkg::UOP_PIXEL: begin
                r_col <= r_col + CRD_W'(1);
            end
            sfb_pkg::UOP_STEP: begin
                r_row <= r_row_dn ? r_row - CRD_W'(1) : r_row + CRD_W'(1);
                if (r_widen) begin
                    r_lo <= r_lo - CRD_W'(1);
                    r_hi <= r_hi + CRD_W'(1);
                end
                r_cnt <= r_cnt - CNT_W'(1);
            end
            default: begin
                r_col <= r_col;
            end
        endcase
    end

    // Result register: loaded at the final step, emptied when taken.
    assign out_free = !r_out_valid || !i_rsp_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.op == sfb_pkg::UOP_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_rsp_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.op == sfb_pkg::UOP_DONE && out_free) begin
            r_out_char <= r_rd_ok ? r_rd_data : 8'h00;
            r_out_ok   <= r_rd_ok;
        end
    end

    assign o_rsp_valid       = r_out_valid;
    assign o_rsp.pixel_char  = r_out_char;
    assign o_rsp.pixel_valid = r_out_ok;

    // Status for the sequencer's jumps.
    assign o_stat.sweep_end = (r_sweep == ADDR_W'(sfb_pkg::DEPTH - 1));
    assign o_stat.cnt_zero  = (r_cnt == '0);
    assign o_stat.col_end   = (r_col == r_hi);
    assign o_stat.out_free  = out_free;

    // A pixel step only runs inside a live span.
    a_pixel_has_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.op == sfb_pkg::UOP_PIXEL |-> r_cnt != '0)
        else $error("pixel step with no span left");

    // The pixel walk never runs past the right edge of its span.
    a_pixel_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.op == sfb_pkg::UOP_PIXEL |-> r_col <= r_hi)
        else $error("pixel column beyond span end");

    // A final step with a free result register always presents a result.
    a_done_presents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.op == sfb_pkg::UOP_DONE && out_free |=> r_out_valid)
        else $error("final step lost its result");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for shape_fill_framebuffer: a directed table, then random requests
// under several clip settings, checked against typed-in results or a behavioural canvas model.
// Depends on sfb_pkg and the RTL under hw/rtl.

module testbench;

    // Mode codes that the block does not use.
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    // Register indexes.
    localparam int REG_ROWS = 0;
    localparam int REG_COLS = 1;
    localparam int SETTLE      = 16;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 14;

    // One row of the directed table: the request and, where typed in, its result.
    typedef struct packed {
        sfb_pkg::t_req req;
        logic          typed;
        sfb_pkg::t_rsp rsp;
    } t_plan_row;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_req_valid = 1'b0;
    sfb_pkg::t_req               i_req       = '0;
    logic                        i_rsp_stall = 1'b0;
    logic                        psel        = 1'b0;
    logic                        penable     = 1'b0;
    logic                        pwrite      = 1'b0;
    logic [sfb_pkg::PADDR_W-1:0] paddr       = '0;
    logic [sfb_pkg::PDATA_W-1:0] pwdata      = '0;
    logic                        o_req_stall;
    logic                        o_rsp_valid;
    sfb_pkg::t_rsp               o_rsp;
    logic [sfb_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    // Canvas model and the clip registers as last written.
    logic [7:0]                canvas [sfb_pkg::MAX_ROWS*sfb_pkg::MAX_COLS];
    logic [sfb_pkg::CFG_W-1:0] rows_reg = 7'd64;
    logic [sfb_pkg::CFG_W-1:0] cols_reg = 7'd64;

    sfb_pkg::t_rsp pending_pixels [$];
    longint work_budget = 0;
    longint cycles      = 0;
    int     mismatches  = 0;
    int     mode_count [8];
    int     reads_inside = 0;
    bit     calm = 1'b0;
    int     stall_left = 0;
    int     run_left   = 0;

    // Clip settings of the random phases, from narrow to beyond the store and back.
    int phase_rows [NUM_PHASES] = '{17, 0, 127, 1, 9, 64, 40, 64};
    int phase_cols [NUM_PHASES] = '{40, 5, 100, 1, 0, 1, 64, 64};

    shape_fill_framebuffer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // Limits actually applied are the register values capped at the store size.
    function automatic int rows_lim();
        return (rows_reg < sfb_pkg::MAX_ROWS) ? int'(rows_reg) : sfb_pkg::MAX_ROWS;
    endfunction

    function automatic int cols_lim();
        return (cols_reg < sfb_pkg::MAX_COLS) ? int'(cols_reg) : sfb_pkg::MAX_COLS;
    endfunction

    function automatic bit on_canvas(input int row, input int col);
        return row >= 0 && row < rows_lim() && col >= 0 && col < cols_lim();
    endfunction

    // Each attempted pixel counts as engine work, clipped or not.
    task automatic plot(input int row, input int col, input logic [7:0] ch);
        work_budget++;
        if (on_canvas(row, col))
            canvas[row*sfb_pkg::MAX_COLS + col] = ch;
    endtask

    task automatic plot_span(input int row, input int cx, input int half, input logic [7:0] ch);
        work_budget += 2;
        for (int col = cx - half; col <= cx + half; col++)
            plot(row, col, ch);
    endtask

    // Applies one request to the canvas model and works out its result.
    task automatic paint(input sfb_pkg::t_req q, output sfb_pkg::t_rsp o);
        int x, y, w, h;
        x = $signed(q.pos_col);
        y = $signed(q.pos_row);
        w = q.width;
        h = q.height;
        o = '0;
        work_budget += 40;
        mode_count[q.mode]++;
        case (q.mode)
            sfb_pkg::MODE_CLEAR: begin
                for (int row = 0; row < rows_lim(); row++)
                    for (int col = 0; col < cols_lim(); col++)
                        canvas[row*sfb_pkg::MAX_COLS + col] = sfb_pkg::DOT_CHAR;
                work_budget += sfb_pkg::MAX_ROWS * (sfb_pkg::MAX_COLS + 2);
            end
            sfb_pkg::MODE_RECT: begin
                for (int i = 0; i < h; i++) begin
                    work_budget += 2;
                    for (int c = 0; c < w; c++)
                        plot(y + i, x + c, q.brush_char);
                end
            end
            sfb_pkg::MODE_UP: begin
                for (int i = 0; i < h; i++)
                    plot_span(y + i, x, i, q.brush_char);
            end
            sfb_pkg::MODE_DOWN: begin
                for (int i = 0; i < h; i++)
                    plot_span(y - i, x, i, q.brush_char);
            end
            sfb_pkg::MODE_DIAMOND: begin
                for (int i = 0; i <= h; i++)
                    plot_span(y + i, x, i, q.brush_char);
                for (int i = 0; i < h; i++)
                    plot_span(y + 2*h - i, x, i, q.brush_char);
            end
            sfb_pkg::MODE_READ: begin
                if (on_canvas(y, x)) begin
                    o.pixel_char  = canvas[y*sfb_pkg::MAX_COLS + x];
                    o.pixel_valid = 1'b1;
                    reads_inside++;
                end
            end
            default: ;
        endcase
    endtask

    function automatic t_plan_row plan_row(input logic [2:0] mode, input int col, input int row,
                                           input int w, input int h, input logic [7:0] ch,
                                           input logic typed, input logic [7:0] want_ch,
                                           input logic want_ok);
        t_plan_row e;
        e.req.mode        = mode;
        e.req.pos_col     = 8'(col);
        e.req.pos_row     = 8'(row);
        e.req.width       = 7'(w);
        e.req.height      = 7'(h);
        e.req.brush_char  = ch;
        e.typed           = typed;
        e.rsp.pixel_char  = want_ch;
        e.rsp.pixel_valid = want_ok;
        return e;
    endfunction

    // Mostly small shapes near the canvas, now and then full-range fields.
    function automatic sfb_pkg::t_req random_req();
        sfb_pkg::t_req q;
        int            pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)      q.mode = sfb_pkg::MODE_READ;
        else if (pick < 56) q.mode = sfb_pkg::MODE_RECT;
        else if (pick < 68) q.mode = sfb_pkg::MODE_UP;
        else if (pick < 80) q.mode = sfb_pkg::MODE_DOWN;
        else if (pick < 92) q.mode = sfb_pkg::MODE_DIAMOND;
        else if (pick < 96) q.mode = sfb_pkg::MODE_CLEAR;
        else if (pick < 98) q.mode = MODE_SPARE_LO;
        else                q.mode = MODE_SPARE_HI;
        if ($urandom_range(0, 9) == 0) begin
            q.pos_col = 8'($urandom);
            q.pos_row = 8'($urandom);
        end else begin
            q.pos_col = 8'(int'($urandom_range(0, cols_lim() + 7)) - 4);
            q.pos_row = 8'(int'($urandom_range(0, rows_lim() + 7)) - 4);
        end
        if ($urandom_range(0, 19) == 0) begin
            q.width  = 7'($urandom);
            q.height = 7'($urandom);
        end else begin
            q.width  = 7'($urandom_range(0, 12));
            q.height = 7'($urandom_range(0, 12));
        end
        q.brush_char = 8'($urandom);
        return q;
    endfunction

    // Presents one request after an optional gap and records its expected result.
    task automatic push_req(input sfb_pkg::t_req q, input logic typed,
                            input sfb_pkg::t_rsp typed_rsp);
        int            gap;
        sfb_pkg::t_rsp want;
        gap = (!calm && $urandom_range(0, 2) == 0) ? $urandom_range(1, 14) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_req_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_req_valid <= 1'b1;
        i_req       <= q;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
        paint(q, want);
        pending_pixels.push_back(typed ? typed_rsp : want);
    endtask

    // Holds requests back until every result is in and the engine has settled.
    task automatic drain();
        @(negedge i_clk);
        i_req_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Writes a clip register, then reads it back.
    task automatic reg_write(input int idx, input logic [sfb_pkg::CFG_W-1:0] val);
        logic [sfb_pkg::PDATA_W-1:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= sfb_pkg::PADDR_W'(idx * 4);
        pwdata  <= sfb_pkg::PDATA_W'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_ROWS) rows_reg = val;
        else cols_reg = val;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        got = prdata;
        if (got !== sfb_pkg::PDATA_W'(val)) begin
            mismatches++;
            $display("%0t: register %0d read back: expected %0h, got %0h",
                     $time, idx, val, got);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side stalls in random bursts, with long free stretches now and then.
    always @(negedge i_clk) begin
        if (calm || !i_rst_n) begin
            i_rsp_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_rsp_stall <= 1'b1;
            stall_left--;
        end else if (run_left > 0) begin
            i_rsp_stall <= 1'b0;
            run_left--;
        end else if ($urandom_range(0, 1) == 1) begin
            i_rsp_stall <= 1'b1;
            stall_left = $urandom_range(0, 13);
        end else begin
            i_rsp_stall <= 1'b0;
            run_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(0, 20);
        end
    end

    // Every accepted result is matched against the oldest expectation.
    always @(posedge i_clk) begin : rsp_check
        sfb_pkg::t_rsp want;
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            if (pending_pixels.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result: expected none, got char %02h valid %0b",
                         $time, o_rsp.pixel_char, o_rsp.pixel_valid);
            end else begin
                want = pending_pixels.pop_front();
                if (o_rsp.pixel_char !== want.pixel_char ||
                    o_rsp.pixel_valid !== want.pixel_valid) begin
                    mismatches++;
                    $display("%0t: result mismatch: expected char %02h valid %0b,",
                             $time, want.pixel_char, want.pixel_valid,
                             " got char %02h valid %0b",
                             o_rsp.pixel_char, o_rsp.pixel_valid);
                end
            end
        end
    end

    // The limit grows with the work of every accepted request.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 4 * work_budget + 60000) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycles, pending_pixels.size());
            $display("** shape_fill_framebuffer: FAILED **");
            $finish;
        end
    end

    initial begin
        t_plan_row plan [$];
        foreach (canvas[k]) canvas[k] = sfb_pkg::DOT_CHAR;
        foreach (mode_count[k]) mode_count[k] = 0;

        // Edges of the field ranges, every mode and the zero-size and clipping cases.
        plan.push_back(plan_row(sfb_pkg::MODE_READ, 0, 0, 0, 0, 8'h00,
                                1'b1, sfb_pkg::DOT_CHAR, 1'b1));
        plan.push_back(plan_row(sfb_pkg::MODE_READ, 63, 63, 0, 0, 8'hFF,
                                1'b1, sfb_pkg::DOT_CHAR, 1'b1));
        plan.push_back(plan_row(sfb_pkg::MODE_READ, -1, 0, 0, 0, 8'h00, 1'b1, 8'h00, 1'b0));
        plan.push_back(plan_row(sfb_pkg::MODE_READ, 0, 64, 0, 0, 8'h00, 1'b1, 8'h00, 1'b0));
        plan.push_back(plan_row(sfb_pkg::MODE_READ, -128, 127, 127, 127, 8'hFF,
                                1'b1, 8'h00, 1'b0));
        plan.push_back(plan_row(sfb_pkg::MODE_READ, 127, -128, 0, 0, 8'h00, 1'b1, 8'h00, 1'b0));
        plan.push_back(plan_row(sfb_pkg::MODE_RECT, -2, -2, 5, 4, 8'hFF, 1'b1, 8'h00, 1'b0));
        plan.push_back(plan_row(sfb_pkg::MODE_READ, 2, 1, 0, 0, 8'h00, 1'b0, 8'h00, 1'b0));
        plan.push_back(plan_row(sfb_pkg::MODE_RECT, 5, 5, 0, 10, 8'h5A, 1'b1, 8'h00, 1'b0));
        plan.push_back(plan_row(sfb_pkg::MODE_RECT, 5, 5, 10, 0, 8'h5A, 1'b1, 8'h00, 1'b0));
        plan.push_back(plan_row(sfb_pkg::MODE_READ, 5, 5, 0, 0, 8'h00, 1'b0, 8'h00, 1'b0));
        plan.push_back(plan_row(sfb_pkg::MODE_UP, 30, 10, 0, 5, 8'h5E, 1'b1, 8'h00, 1'b0));
        plan.push_back(plan_row(sfb_pkg::MODE_UP, 0, 0, 0, 0, 8'h00, 1'b1, 8'h00, 1'b0));
        plan.push_back(plan_row(sfb_pkg::MODE_READ, 26, 14, 0, 0, 8'h00, 1'b0, 8'h00, 1'b0));
        plan.push_back(plan_row(sfb_pkg::MODE_DOWN, 2, 40, 0, 8, 8'h76, 1'b1, 8'h00, 1'b0));
        plan.push_back(plan_row(sfb_pkg::MODE_READ, 0, 34, 0, 0, 8'h00, 1'b0, 8'h00, 1'b0));
        plan.push_back(plan_row(sfb_pkg::MODE_DIAMOND, 50, 50, 0, 0, 8'h6F, 1'b1, 8'h00, 1'b0));
        plan.push_back(plan_row(sfb_pkg::MODE_READ, 50, 50, 0, 0, 8'h00, 1'b0, 8'h00, 1'b0));
        plan.push_back(plan_row(sfb_pkg::MODE_DIAMOND, 62, 20, 0, 3, 8'h2A, 1'b1, 8'h00, 1'b0));
        plan.push_back(plan_row(sfb_pkg::MODE_READ, 63, 23, 0, 0, 8'h00, 1'b0, 8'h00, 1'b0));
        plan.push_back(plan_row(MODE_SPARE_LO, 3, 3, 4, 4, 8'h41, 1'b1, 8'h00, 1'b0));
        plan.push_back(plan_row(MODE_SPARE_HI, 3, 3, 4, 4, 8'h41, 1'b1, 8'h00, 1'b0));
        plan.push_back(plan_row(sfb_pkg::MODE_RECT, -64, -64, 127, 127, 8'h23,
                                1'b1, 8'h00, 1'b0));
        plan.push_back(plan_row(sfb_pkg::MODE_DIAMOND, 32, 0, 0, 127, 8'h55,
                                1'b1, 8'h00, 1'b0));
        plan.push_back(plan_row(sfb_pkg::MODE_CLEAR, 0, 0, 0, 0, 8'h00, 1'b1, 8'h00, 1'b0));
        plan.push_back(plan_row(sfb_pkg::MODE_READ, 62, 62, 0, 0, 8'h00,
                                1'b1, sfb_pkg::DOT_CHAR, 1'b1));

        // Synchronous reset, then the clip registers at their full size.
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        reg_write(REG_ROWS, 7'd64);
        reg_write(REG_COLS, 7'd64);

        foreach (plan[k]) push_req(plan[k].req, plan[k].typed, plan[k].rsp);

        // Random phases, each opened once the block has gone idle.
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            calm = (p == NUM_PHASES - 1);
            reg_write(REG_ROWS, 7'(phase_rows[p]));
            reg_write(REG_COLS, 7'(phase_cols[p]));
            repeat (PHASE_ITEMS) push_req(random_req(), 1'b0, '0);
        end
        drain();

        $display("Run covered %0d clears, %0d rectangles, %0d triangles, %0d diamonds,",
                 mode_count[sfb_pkg::MODE_CLEAR], mode_count[sfb_pkg::MODE_RECT],
                 mode_count[sfb_pkg::MODE_UP] + mode_count[sfb_pkg::MODE_DOWN],
                 mode_count[sfb_pkg::MODE_DIAMOND]);
        $display("%0d spare codes and %0d reads (%0d inside the canvas) over %0d clip settings.",
                 mode_count[MODE_SPARE_LO] + mode_count[MODE_SPARE_HI],
                 mode_count[sfb_pkg::MODE_READ], reads_inside, NUM_PHASES + 1);
        if (mismatches == 0) begin
            $display("** shape_fill_framebuffer: PASSED **");
        end else begin
            $display("** shape_fill_framebuffer: FAILED **");
        end
        $finish;
    end

endmodule
